>>> sv/sacl_pkg.sv
// Shared types and constants for the set-associative cache lookup block.
// Holds result codes, register indexes, reset values, widths and the victim LFSR step function.
// No dependencies.
package sacl_pkg;

    // Result classification of one access
    typedef enum logic [1:0] {
        OUT_HIT        = 2'd0,
        OUT_COMPULSORY = 2'd1,
        OUT_CAPACITY   = 2'd2,
        OUT_CONFLICT   = 2'd3
    } outcome_t;

    // Configuration register indexes
    localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [1:0] REG_WAY_BITS    = 2'd2;

    // Register reset values
    localparam logic [3:0] OFFSET_BITS_RST = 4'd2;
    localparam logic [3:0] INDEX_BITS_RST  = 4'd8;
    localparam logic [1:0] WAY_BITS_RST    = 2'd0;

    // Tag and address widths
    localparam int ADDR_W = 32;
    localparam int TAG_W  = 32;

    // Victim LFSR
    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    typedef logic [15:0] lfsr_t;

    // Fibonacci LFSR, taps 16,14,13,11: shift right, feedback into the top bit
    function automatic lfsr_t lfsr_next(input lfsr_t v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[15:1]};
    endfunction

endpackage

>>> sv/sacl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// A read at the address being written returns the old contents.
// No dependencies.
module sacl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/set_assoc_cache_lookup_random_top.sv
// Set-associative cache lookup with random replacement: top level.
// Depends on sacl_pkg and sacl_ram.
//
// Each accepted address is split into offset, set index and tag by the configured
// widths, the set's row (valid bits and tags of all ways) is read from one tag RAM,
// classified as hit, compulsory, capacity or conflict miss, and written back when the
// result moves to the output register. The block sustains one address per cycle while
// results are taken; an address passes through stage one into the output register, and
// stage one holds while the output register holds an earlier result that m_ready has not
// taken. The rate is set by the tag RAM's read-modify-write: a row written back is
// forwarded to a read of the same set issued in the same cycle. After reset a clearing
// pass zeroes the valid bits of every set, during which s_ready stays low; configuration
// writes are taken at any time but must only be made while the block is idle.
module set_assoc_cache_lookup_random_top #(
    parameter int SETS = 256,
    parameter int WAYS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_wdata,
    // Address input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_address,
    // Result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_outcome,
    output logic [1:0]  m_way_used,
    output logic [7:0]  m_set_used
);

    import sacl_pkg::*;

    // Ways that can ever be in use: power of two not above WAYS, at most 8
    localparam int NW    = (WAYS >= 8) ? 8 : (WAYS >= 4) ? 4 : (WAYS >= 2) ? 2 : 1;
    localparam int WIW   = (NW > 1) ? $clog2(NW) : 1;
    localparam int MAXWB = $clog2(NW);
    localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int MAXIB = $clog2(SETS + 1) - 1;
    localparam int LFW   = $clog2(NW * SETS + 1);
    localparam int ROWW  = NW * (TAG_W + 1);

    // Configuration registers
    logic [3:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [1:0] way_bits_reg;

    // Control state
    logic            clearing_reg, clearing_next;
    logic [SW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic            s1_valid_reg, s1_valid_next;
    logic            fwd_valid_reg, fwd_valid_next;
    logic            out_valid_reg, out_valid_next;
    logic [LFW-1:0]  lines_filled_reg, lines_filled_next;
    lfsr_t           lfsr_reg, lfsr_next_val;

    // Payload state
    logic [SW-1:0]    s1_set_reg;
    logic [TAG_W-1:0] s1_tag_reg;
    logic [ROWW-1:0]  fwd_row_reg;
    outcome_t         out_outcome_reg;
    logic [1:0]       out_way_reg;
    logic [7:0]       out_set_reg;

    // Handshake
    logic accept;
    logic advance;

    // Effective widths
    logic [1:0]       wb_eff;
    logic [3:0]       ib_eff;
    logic [3:0]       ways;
    logic [WIW-1:0]   ways_m1;
    logic [NW-1:0]    way_en;
    logic [LFW-1:0]   in_use;

    // Address split
    logic [ADDR_W-1:0] addr_shift;
    logic [ADDR_W-1:0] set_mask;
    logic [SW-1:0]     set_in;
    logic [TAG_W-1:0]  tag_in;
    logic [4:0]        tag_shift;

    // Row handling
    logic [ROWW-1:0]              ram_rdata;
    logic [ROWW-1:0]              cur_row;
    logic [NW-1:0]                cur_vld;
    logic [NW-1:0][TAG_W-1:0]     cur_tag;
    logic [NW-1:0]                new_vld;
    logic [NW-1:0][TAG_W-1:0]     new_tag;
    logic [ROWW-1:0]              new_row;
    logic                         found;
    logic                         is_comp;
    logic [WIW-1:0]               way_sel;
    logic [WIW-1:0]               victim;
    logic [WIW-1:0]               way_fin;
    outcome_t                     outcome;

    // RAM ports
    logic            ram_we;
    logic [SW-1:0]   ram_waddr;
    logic [ROWW-1:0] ram_wdata;

    // Clamp configuration to what the geometry supports
    always_comb begin
        wb_eff  = (way_bits_reg > 2'(MAXWB)) ? 2'(MAXWB) : way_bits_reg;
        ib_eff  = (index_bits_reg > 4'(MAXIB)) ? 4'(MAXIB) : index_bits_reg;
        ways    = 4'd1 << wb_eff;
        ways_m1 = WIW'(ways - 4'd1);
        for (int k = 0; k < NW; k++) begin
            way_en[k] = (4'(k) < ways);
        end
        in_use  = LFW'(32'd1 << (5'(wb_eff) + 5'(ib_eff)));
    end

    // Split the incoming address
    always_comb begin
        addr_shift = s_address >> offset_bits_reg;
        set_mask   = 32'((33'd1 << ib_eff) - 33'd1);
        set_in     = SW'(addr_shift & set_mask);
        tag_shift  = 5'(offset_bits_reg) + 5'(ib_eff);
        tag_in     = s_address >> tag_shift;
    end

    // Handshake: stage one advances when the output register is free or draining
    assign advance = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !clearing_reg && (!s1_valid_reg || advance);
    assign accept  = s_valid && s_ready;

    // Select the row: forwarded write-back or RAM data
    assign cur_row = fwd_valid_reg ? fwd_row_reg : ram_rdata;
    assign cur_vld = cur_row[ROWW-1 -: NW];
    assign cur_tag = cur_row[NW*TAG_W-1:0];

    // Scan ways, classify and build the updated row
    always_comb begin
        found   = 1'b0;
        is_comp = 1'b0;
        way_sel = '0;
        for (int k = 0; k < NW; k++) begin
            if (way_en[k] && !found && (!cur_vld[k] || cur_tag[k] == s1_tag_reg)) begin
                found   = 1'b1;
                is_comp = !cur_vld[k];
                way_sel = WIW'(k);
            end
        end
        victim  = lfsr_reg[WIW-1:0] & ways_m1;
        new_vld = cur_vld;
        new_tag = cur_tag;
        if (!found) begin
            way_fin          = victim;
            new_tag[victim]  = s1_tag_reg;
            outcome          = (lines_filled_reg >= in_use) ? OUT_CAPACITY : OUT_CONFLICT;
        end else if (is_comp) begin
            way_fin          = way_sel;
            new_vld[way_sel] = 1'b1;
            new_tag[way_sel] = s1_tag_reg;
            outcome          = OUT_COMPULSORY;
        end else begin
            way_fin          = way_sel;
            outcome          = OUT_HIT;
        end
        new_row = {new_vld, new_tag};
    end

    // RAM write: clearing pass or write-back
    always_comb begin
        ram_we    = clearing_reg || advance;
        ram_waddr = clearing_reg ? clr_cnt_reg : s1_set_reg;
        ram_wdata = clearing_reg ? '0 : new_row;
    end

    sacl_ram #(
        .WIDTH (ROWW),
        .DEPTH (SETS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (set_in),
        .rdata (ram_rdata)
    );

    // Next-state logic for control
    always_comb begin
        clearing_next     = clearing_reg;
        clr_cnt_next      = clr_cnt_reg;
        s1_valid_next     = s1_valid_reg;
        fwd_valid_next    = fwd_valid_reg;
        out_valid_next    = out_valid_reg;
        lines_filled_next = lines_filled_reg;
        lfsr_next_val     = lfsr_reg;

        // Sweep the valid bits after reset
        if (clearing_reg) begin
            clr_cnt_next = clr_cnt_reg + SW'(1);
            if (clr_cnt_reg == SW'(SETS - 1)) begin
                clearing_next = 1'b0;
            end
        end

        // Stage one occupancy and forwarding
        if (accept) begin
            s1_valid_next  = 1'b1;
            fwd_valid_next = advance && (set_in == s1_set_reg);
        end else if (advance) begin
            s1_valid_next  = 1'b0;
            fwd_valid_next = 1'b0;
        end

        // Output register and replacement state
        if (advance) begin
            out_valid_next = 1'b1;
            if (!found) begin
                lfsr_next_val = lfsr_next(lfsr_reg);
            end
            if (found && is_comp) begin
                lines_filled_next = lines_filled_reg + LFW'(1);
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg     <= 1'b1;
            clr_cnt_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            lines_filled_reg <= '0;
            lfsr_reg         <= LFSR_SEED;
        end else begin
            clearing_reg     <= clearing_next;
            clr_cnt_reg      <= clr_cnt_next;
            s1_valid_reg     <= s1_valid_next;
            fwd_valid_reg    <= fwd_valid_next;
            out_valid_reg    <= out_valid_next;
            lines_filled_reg <= lines_filled_next;
            lfsr_reg         <= lfsr_next_val;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= OFFSET_BITS_RST;
            index_bits_reg  <= INDEX_BITS_RST;
            way_bits_reg    <= WAY_BITS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_OFFSET_BITS: offset_bits_reg <= cfg_wdata;
                REG_INDEX_BITS:  index_bits_reg  <= cfg_wdata;
                REG_WAY_BITS:    way_bits_reg    <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_set_reg <= set_in;
            s1_tag_reg <= tag_in;
        end
        if (accept && advance) begin
            fwd_row_reg <= new_row;
        end
        if (advance) begin
            out_outcome_reg <= outcome;
            out_way_reg     <= 2'(way_fin);
            out_set_reg     <= 8'(s1_set_reg);
        end
    end

    // Output ports
    assign m_valid    = out_valid_reg;
    assign m_outcome  = out_outcome_reg;
    assign m_way_used = out_way_reg;
    assign m_set_used = out_set_reg;

endmodule

>>> sv/sacl_checker.sv
// Port-level checker for the set-associative cache lookup block, bound to the top level.
// Depends on set_assoc_cache_lookup_random_top.
// Tracks items in flight and checks the in-flight bound, stalled results and the clearing pass.
module sacl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_outcome,
    input logic [1:0]  m_way_used,
    input logic [7:0]  m_set_used
);

    logic [2:0] inflight_reg, inflight_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;

    // Count items accepted but not yet delivered
    always_comb begin
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer) begin
            inflight_next = inflight_reg + 3'd1;
        end else if (out_xfer && !in_xfer) begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // At most one item in the lookup stage and one in the output register
    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 3'd2)
        else $error("more than two items in flight");

    // A result is shown only for an item that was accepted
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != 3'd0)
        else $error("result without an accepted item");

    // No transfer is taken when reset is released, while the valid bits clear
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_ready)
        else $error("input ready during clearing pass");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_outcome) && $stable(m_way_used)
            && $stable(m_set_used))
        else $error("stalled result changed");

endmodule

bind set_assoc_cache_lookup_random_top sacl_checker u_sacl_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_outcome  (m_outcome),
    .m_way_used (m_way_used),
    .m_set_used (m_set_used)
);
